### sv/dual_tone_sine_generator_assert.svh
// ----------------------------------------------------------------------------
// Dual-tone sine generator assertion macros
// Shared assertion forms, clocked on the rising edge, off during reset.
// ----------------------------------------------------------------------------
`ifndef DUAL_TONE_SINE_GENERATOR_ASSERT_SVH
`define DUAL_TONE_SINE_GENERATOR_ASSERT_SVH

// expression holds at every edge
`define DTSG_ASSERT_ALWAYS(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("dtsg: invariant violated");

// consequent holds in the cycle after the antecedent
`define DTSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("dtsg: next-cycle check violated");

`endif

### sv/dtsg_pkg.sv
// ----------------------------------------------------------------------------
// dtsg_pkg
// Types, register codes, constants and sine tables of the dual-tone generator.
// ----------------------------------------------------------------------------
`default_nettype none

package dtsg_pkg;

	localparam int TABLE_LEN      = 480;
	localparam int HALF_LEN       = 240;
	localparam int QUARTER_LEN    = 120;
	localparam int COEF_FRAC_BITS = 30;
	localparam int SAMPLE_SCALE   = 32767;

	typedef logic signed [31:0] coef_t;
	typedef logic signed [15:0] smp_t;
	typedef logic [8:0]         phase_t;
	typedef logic [17:0]        count_t;

	localparam coef_t ONE_Q = coef_t'(1 << COEF_FRAC_BITS);

	typedef enum logic [1:0] {
		MODE_FULL    = 2'd0,
		MODE_QUARTER = 2'd1,
		MODE_PHASOR  = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		REG_MODE       = 3'd0,
		REG_STEP_A     = 3'd1,
		REG_STEP_B     = 3'd2,
		REG_ROT_COS_A  = 3'd3,
		REG_ROT_SIN_A  = 3'd4,
		REG_ROT_COS_B  = 3'd5,
		REG_ROT_SIN_B  = 3'd6,
		REG_RESYNC_LEN = 3'd7
	} cfg_reg_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] step_a;
		logic [7:0] step_b;
		coef_t      rot_cos_a;
		coef_t      rot_sin_a;
		coef_t      rot_cos_b;
		coef_t      rot_sin_b;
		count_t     resync_len;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		mode:       MODE_QUARTER,
		step_a:     8'd8,
		step_b:     8'd20,
		rot_cos_a:  32'sd1070935623,
		rot_sin_a:  32'sd112543153,
		rot_cos_b:  32'sd1056431545,
		rot_sin_b:  32'sd192005035,
		resync_len: 18'd184320
	};

	typedef struct packed {
		logic advance;
		logic restart;
		logic resync;
	} tone_ctl_t;

	typedef struct packed {
		smp_t sample_a;
		smp_t sample_b;
		logic wrapped;
	} result_t;

	localparam smp_t WAVE_POS [HALF_LEN] = '{
		  16'sd0,   16'sd427,   16'sd856,  16'sd1285,  16'sd1713,
		 16'sd2142,  16'sd2569,  16'sd2997,  16'sd3424,  16'sd3850,
		 16'sd4276,  16'sd4700,  16'sd5125,  16'sd5548,  16'sd5970,
		 16'sd6391,  16'sd6811,  16'sd7230,  16'sd7648,  16'sd8064,
		 16'sd8479,  16'sd8893,  16'sd9305,  16'sd9716, 16'sd10124,
		16'sd10531, 16'sd10937, 16'sd11340, 16'sd11742, 16'sd12141,
		16'sd12538, 16'sd12933, 16'sd13326, 16'sd13717, 16'sd14105,
		16'sd14491, 16'sd14875, 16'sd15256, 16'sd15634, 16'sd16010,
		16'sd16382, 16'sd16753, 16'sd17120, 16'sd17484, 16'sd17845,
		16'sd18203, 16'sd18558, 16'sd18910, 16'sd19259, 16'sd19604,
		16'sd19946, 16'sd20285, 16'sd20620, 16'sd20952, 16'sd21280,
		16'sd21604, 16'sd21925, 16'sd22241, 16'sd22555, 16'sd22864,
		16'sd23169, 16'sd23470, 16'sd23768, 16'sd24061, 16'sd24350,
		16'sd24635, 16'sd24915, 16'sd25192, 16'sd25464, 16'sd25732,
		16'sd25995, 16'sd26254, 16'sd26508, 16'sd26758, 16'sd27003,
		16'sd27244, 16'sd27480, 16'sd27711, 16'sd27938, 16'sd28160,
		16'sd28376, 16'sd28588, 16'sd28796, 16'sd28998, 16'sd29195,
		16'sd29387, 16'sd29574, 16'sd29757, 16'sd29934, 16'sd30105,
		16'sd30272, 16'sd30434, 16'sd30590, 16'sd30741, 16'sd30887,
		16'sd31028, 16'sd31163, 16'sd31293, 16'sd31417, 16'sd31536,
		16'sd31650, 16'sd31758, 16'sd31861, 16'sd31959, 16'sd32050,
		16'sd32137, 16'sd32218, 16'sd32293, 16'sd32363, 16'sd32427,
		16'sd32486, 16'sd32539, 16'sd32587, 16'sd32629, 16'sd32665,
		16'sd32696, 16'sd32722, 16'sd32741, 16'sd32755, 16'sd32764,
		16'sd32767, 16'sd32764, 16'sd32755, 16'sd32741, 16'sd32722,
		16'sd32696, 16'sd32665, 16'sd32629, 16'sd32587, 16'sd32539,
		16'sd32486, 16'sd32427, 16'sd32363, 16'sd32293, 16'sd32218,
		16'sd32137, 16'sd32050, 16'sd31959, 16'sd31861, 16'sd31758,
		16'sd31650, 16'sd31536, 16'sd31417, 16'sd31293, 16'sd31163,
		16'sd31028, 16'sd30887, 16'sd30741, 16'sd30590, 16'sd30434,
		16'sd30272, 16'sd30105, 16'sd29934, 16'sd29757, 16'sd29574,
		16'sd29387, 16'sd29195, 16'sd28998, 16'sd28796, 16'sd28588,
		16'sd28376, 16'sd28160, 16'sd27938, 16'sd27711, 16'sd27480,
		16'sd27244, 16'sd27003, 16'sd26758, 16'sd26508, 16'sd26254,
		16'sd25995, 16'sd25732, 16'sd25464, 16'sd25192, 16'sd24915,
		16'sd24635, 16'sd24350, 16'sd24061, 16'sd23768, 16'sd23470,
		16'sd23169, 16'sd22864, 16'sd22555, 16'sd22241, 16'sd21925,
		16'sd21604, 16'sd21280, 16'sd20952, 16'sd20620, 16'sd20285,
		16'sd19946, 16'sd19604, 16'sd19259, 16'sd18910, 16'sd18558,
		16'sd18203, 16'sd17845, 16'sd17484, 16'sd17120, 16'sd16753,
		16'sd16383, 16'sd16010, 16'sd15634, 16'sd15256, 16'sd14875,
		16'sd14491, 16'sd14105, 16'sd13717, 16'sd13326, 16'sd12933,
		16'sd12538, 16'sd12141, 16'sd11742, 16'sd11340, 16'sd10937,
		16'sd10531, 16'sd10124,  16'sd9716,  16'sd9305,  16'sd8893,
		 16'sd8479,  16'sd8064,  16'sd7648,  16'sd7230,  16'sd6811,
		 16'sd6391,  16'sd5970,  16'sd5548,  16'sd5125,  16'sd4700,
		 16'sd4276,  16'sd3850,  16'sd3424,  16'sd2997,  16'sd2569,
		 16'sd2142,  16'sd1713,  16'sd1285,   16'sd856,   16'sd427
	};

	localparam smp_t WAVE_NEG [HALF_LEN] = '{
		     16'sd0,   -16'sd429,   -16'sd858,  -16'sd1287,  -16'sd1715,
		 -16'sd2144,  -16'sd2571,  -16'sd2999,  -16'sd3426,  -16'sd3852,
		 -16'sd4278,  -16'sd4702,  -16'sd5127,  -16'sd5550,  -16'sd5972,
		 -16'sd6393,  -16'sd6813,  -16'sd7232,  -16'sd7650,  -16'sd8066,
		 -16'sd8481,  -16'sd8895,  -16'sd9307,  -16'sd9718, -16'sd10126,
		-16'sd10533, -16'sd10939, -16'sd11342, -16'sd11744, -16'sd12143,
		-16'sd12540, -16'sd12935, -16'sd13328, -16'sd13719, -16'sd14107,
		-16'sd14493, -16'sd14877, -16'sd15258, -16'sd15636, -16'sd16012,
		-16'sd16384, -16'sd16755, -16'sd17122, -16'sd17486, -16'sd17847,
		-16'sd18205, -16'sd18560, -16'sd18912, -16'sd19261, -16'sd19606,
		-16'sd19948, -16'sd20287, -16'sd20622, -16'sd20954, -16'sd21282,
		-16'sd21606, -16'sd21927, -16'sd22243, -16'sd22557, -16'sd22866,
		-16'sd23171, -16'sd23472, -16'sd23770, -16'sd24063, -16'sd24352,
		-16'sd24637, -16'sd24917, -16'sd25194, -16'sd25466, -16'sd25734,
		-16'sd25997, -16'sd26256, -16'sd26510, -16'sd26760, -16'sd27005,
		-16'sd27246, -16'sd27482, -16'sd27713, -16'sd27940, -16'sd28162,
		-16'sd28378, -16'sd28590, -16'sd28798, -16'sd29000, -16'sd29197,
		-16'sd29389, -16'sd29576, -16'sd29759, -16'sd29936, -16'sd30107,
		-16'sd30274, -16'sd30436, -16'sd30592, -16'sd30743, -16'sd30889,
		-16'sd31030, -16'sd31165, -16'sd31295, -16'sd31419, -16'sd31538,
		-16'sd31652, -16'sd31760, -16'sd31863, -16'sd31961, -16'sd32052,
		-16'sd32139, -16'sd32220, -16'sd32295, -16'sd32365, -16'sd32429,
		-16'sd32488, -16'sd32541, -16'sd32589, -16'sd32631, -16'sd32667,
		-16'sd32698, -16'sd32724, -16'sd32743, -16'sd32757, -16'sd32766,
		-16'sd32767, -16'sd32766, -16'sd32757, -16'sd32743, -16'sd32724,
		-16'sd32698, -16'sd32667, -16'sd32631, -16'sd32589, -16'sd32541,
		-16'sd32488, -16'sd32429, -16'sd32365, -16'sd32295, -16'sd32220,
		-16'sd32139, -16'sd32052, -16'sd31961, -16'sd31863, -16'sd31760,
		-16'sd31652, -16'sd31538, -16'sd31419, -16'sd31295, -16'sd31165,
		-16'sd31030, -16'sd30889, -16'sd30743, -16'sd30592, -16'sd30436,
		-16'sd30274, -16'sd30107, -16'sd29936, -16'sd29759, -16'sd29576,
		-16'sd29389, -16'sd29197, -16'sd29000, -16'sd28798, -16'sd28590,
		-16'sd28378, -16'sd28162, -16'sd27940, -16'sd27713, -16'sd27482,
		-16'sd27246, -16'sd27005, -16'sd26760, -16'sd26510, -16'sd26256,
		-16'sd25997, -16'sd25734, -16'sd25466, -16'sd25194, -16'sd24917,
		-16'sd24637, -16'sd24352, -16'sd24063, -16'sd23770, -16'sd23472,
		-16'sd23171, -16'sd22866, -16'sd22557, -16'sd22243, -16'sd21927,
		-16'sd21606, -16'sd21282, -16'sd20954, -16'sd20622, -16'sd20287,
		-16'sd19948, -16'sd19606, -16'sd19261, -16'sd18912, -16'sd18560,
		-16'sd18205, -16'sd17847, -16'sd17486, -16'sd17122, -16'sd16755,
		-16'sd16385, -16'sd16012, -16'sd15636, -16'sd15258, -16'sd14877,
		-16'sd14493, -16'sd14107, -16'sd13719, -16'sd13328, -16'sd12935,
		-16'sd12540, -16'sd12143, -16'sd11744, -16'sd11342, -16'sd10939,
		-16'sd10533, -16'sd10126,  -16'sd9718,  -16'sd9307,  -16'sd8895,
		 -16'sd8481,  -16'sd8066,  -16'sd7650,  -16'sd7232,  -16'sd6813,
		 -16'sd6393,  -16'sd5972,  -16'sd5550,  -16'sd5127,  -16'sd4702,
		 -16'sd4278,  -16'sd3852,  -16'sd3426,  -16'sd2999,  -16'sd2571,
		 -16'sd2144,  -16'sd1715,  -16'sd1287,   -16'sd858,   -16'sd429
	};

endpackage

`default_nettype wire

### sv/dtsg_in_if.sv
// ----------------------------------------------------------------------------
// dtsg_in_if
// Tick channel into the generator: valid, ready and the restart flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsg_in_if;
	logic valid;
	logic ready;
	logic restart;

	modport source (output valid, output restart, input ready);
	modport sink (input valid, input restart, output ready);
endinterface

`default_nettype wire

### sv/dtsg_out_if.sv
// ----------------------------------------------------------------------------
// dtsg_out_if
// Sample channel out of the generator: valid, ready, one stereo pair and the wrap flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtsg_out_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] sample_a;
	logic signed [15:0] sample_b;
	logic               wrapped;

	modport source (output valid, output sample_a, output sample_b, output wrapped,
		input ready);
	modport sink (input valid, input sample_a, input sample_b, input wrapped,
		output ready);
endinterface

`default_nettype wire

### sv/dtsg_cfg.sv
// ----------------------------------------------------------------------------
// dtsg_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module dtsg_cfg import dtsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic [2:0]  index,
	input  wire logic [31:0] data,
	output cfg_t             cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (wr_en) begin
			case (cfg_reg_t'(index))
				REG_MODE:       cfg_q.mode       <= mode_t'(data[1:0]);
				REG_STEP_A:     cfg_q.step_a     <= data[7:0];
				REG_STEP_B:     cfg_q.step_b     <= data[7:0];
				REG_ROT_COS_A:  cfg_q.rot_cos_a  <= coef_t'(data);
				REG_ROT_SIN_A:  cfg_q.rot_sin_a  <= coef_t'(data);
				REG_ROT_COS_B:  cfg_q.rot_cos_b  <= coef_t'(data);
				REG_ROT_SIN_B:  cfg_q.rot_sin_b  <= coef_t'(data);
				REG_RESYNC_LEN: cfg_q.resync_len <= data[17:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

### sv/dtsg_tone.sv
// ----------------------------------------------------------------------------
// dtsg_tone
// One tone: table phase, rotating phasor and the sample select for all modes.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_tone_sine_generator_assert.svh"

module dtsg_tone import dtsg_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire tone_ctl_t  ctl,
	input  wire mode_t      mode,
	input  wire logic [7:0] step,
	input  wire coef_t      rot_cos,
	input  wire coef_t      rot_sin,
	output smp_t            sample
);

	localparam int ACC_W = 66;
	localparam int SHR_W = ACC_W - COEF_FRAC_BITS;
	localparam int SCL_W = 48;
	localparam int TRN_W = SCL_W - COEF_FRAC_BITS;
	localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(1) <<< (COEF_FRAC_BITS - 1);
	localparam logic signed [SCL_W-1:0] TRUNC_BIAS = (SCL_W'(1) <<< COEF_FRAC_BITS) - 1;
	localparam logic signed [SHR_W-1:0] S32_MAX = SHR_W'(64'sh7FFFFFFF);
	localparam logic signed [SHR_W-1:0] S32_MIN = -SHR_W'(64'sh80000000);
	localparam logic signed [TRN_W-1:0] S16_MAX = TRN_W'(32767);
	localparam logic signed [TRN_W-1:0] S16_MIN = -TRN_W'(32768);

	function automatic coef_t sat32(input logic signed [SHR_W-1:0] v);
		coef_t r;
		if (v > S32_MAX) begin
			r = 32'sh7FFFFFFF;
		end else if (v < S32_MIN) begin
			r = 32'sh80000000;
		end else begin
			r = coef_t'(v[31:0]);
		end
		return r;
	endfunction

	phase_t phase_q;
	coef_t  re_q;
	coef_t  im_q;

	phase_t phase_cur;
	coef_t  re_cur;
	coef_t  im_cur;

	logic [9:0] phase_sum;
	phase_t     phase_nxt;

	logic signed [63:0] p_cr;
	logic signed [63:0] p_si;
	logic signed [63:0] p_sr;
	logic signed [63:0] p_ci;
	logic signed [ACC_W-1:0] acc_re;
	logic signed [ACC_W-1:0] acc_im;
	logic signed [SHR_W-1:0] shr_re;
	logic signed [SHR_W-1:0] shr_im;

	logic signed [SCL_W-1:0] scaled;
	logic signed [TRN_W-1:0] trunc_val;
	smp_t                    ph_sample;

	phase_t     q_idx;
	logic       q_neg;
	logic       upper;
	logic [7:0] pos_addr;
	logic [7:0] neg_addr;
	smp_t       pos_val;
	smp_t       neg_val;

	assign phase_cur = ctl.restart ? '0 : phase_q;
	assign re_cur    = ctl.restart ? '0 : re_q;
	assign im_cur    = ctl.restart ? ONE_Q : im_q;

	assign phase_sum = {1'b0, phase_cur} + {2'b00, step};
	assign phase_nxt = (phase_sum >= 10'(TABLE_LEN)) ? 9'(phase_sum - 10'(TABLE_LEN))
		: phase_sum[8:0];

	assign p_cr = rot_cos * re_cur;
	assign p_si = rot_sin * im_cur;
	assign p_sr = rot_sin * re_cur;
	assign p_ci = rot_cos * im_cur;

	assign acc_re = ACC_W'(p_cr) - ACC_W'(p_si) + ROUND_HALF;
	assign acc_im = ACC_W'(p_sr) + ACC_W'(p_ci) + ROUND_HALF;
	assign shr_re = SHR_W'(acc_re >>> COEF_FRAC_BITS);
	assign shr_im = SHR_W'(acc_im >>> COEF_FRAC_BITS);

	assign scaled    = (SCL_W'(re_cur) <<< 15) - SCL_W'(re_cur);
	assign trunc_val = TRN_W'((scaled + (scaled[SCL_W-1] ? TRUNC_BIAS : '0))
		>>> COEF_FRAC_BITS);
	assign ph_sample = (trunc_val > S16_MAX) ? 16'sh7FFF
		: (trunc_val < S16_MIN) ? 16'sh8000 : smp_t'(trunc_val[15:0]);

	always_comb begin
		upper = (phase_cur >= 9'(HALF_LEN));
		if (phase_cur < 9'(QUARTER_LEN)) begin
			q_idx = phase_cur;
			q_neg = 1'b0;
		end else if (phase_cur < 9'(HALF_LEN)) begin
			q_idx = 9'(HALF_LEN) - phase_cur;
			q_neg = 1'b0;
		end else if (phase_cur < 9'(HALF_LEN + QUARTER_LEN)) begin
			q_idx = phase_cur - 9'(HALF_LEN);
			q_neg = 1'b1;
		end else begin
			q_idx = 9'(TABLE_LEN - 256) - (phase_cur - 9'd256);
			q_neg = 1'b1;
		end
		if (mode == MODE_QUARTER) begin
			pos_addr = q_idx[7:0];
		end else begin
			pos_addr = upper ? '0 : phase_cur[7:0];
		end
		neg_addr = upper ? 8'(phase_cur - 9'(HALF_LEN)) : '0;
	end

	assign pos_val = WAVE_POS[pos_addr];
	assign neg_val = WAVE_NEG[neg_addr];

	always_comb begin
		case (mode)
			MODE_FULL:    sample = upper ? neg_val : pos_val;
			MODE_QUARTER: sample = q_neg ? -pos_val : pos_val;
			MODE_PHASOR:  sample = ph_sample;
			default:      sample = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= '0;
			re_q    <= '0;
			im_q    <= ONE_Q;
		end else if (ctl.advance) begin
			if (ctl.resync) begin
				phase_q <= '0;
				re_q    <= '0;
				im_q    <= ONE_Q;
			end else begin
				phase_q <= phase_nxt;
				re_q    <= sat32(shr_re);
				im_q    <= sat32(shr_im);
			end
		end
	end

	`DTSG_ASSERT_ALWAYS(a_phase_in_table, clk, arst_n, phase_q < 9'(TABLE_LEN))
	`DTSG_ASSERT_NEXT(a_resync_phasor, clk, arst_n, ctl.advance && ctl.resync, phase_q == '0 && re_q == '0 && im_q == ONE_Q)

endmodule

`default_nettype wire

### sv/dtsg_outbuf.sv
// ----------------------------------------------------------------------------
// dtsg_outbuf
// Two-entry result buffer: output register plus skid register.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_tone_sine_generator_assert.svh"

module dtsg_outbuf import dtsg_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  wire result_t push_data,
	output logic         ready,
	dtsg_out_if.source   result
);

	logic    out_valid_q;
	logic    skid_valid_q;
	result_t out_q;
	result_t skid_q;
	logic    pop;

	assign ready = !skid_valid_q;
	assign pop   = out_valid_q && result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_valid_q <= 1'b1;
			end
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (push) begin
			if (out_valid_q && !pop) begin
				skid_q <= push_data;
			end else begin
				out_q <= push_data;
			end
		end
	end

	assign result.valid    = out_valid_q;
	assign result.sample_a = out_q.sample_a;
	assign result.sample_b = out_q.sample_b;
	assign result.wrapped  = out_q.wrapped;

	`DTSG_ASSERT_ALWAYS(a_skid_behind_out, clk, arst_n, !skid_valid_q || out_valid_q)
	`DTSG_ASSERT_NEXT(a_skid_drains, clk, arst_n, skid_valid_q && pop, out_valid_q && !skid_valid_q)

endmodule

`default_nettype wire

### sv/dual_tone_sine_generator.sv
// ----------------------------------------------------------------------------
// dual_tone_sine_generator
// Each accepted tick beat yields one result beat carrying a stereo pair of
// sine samples for tone A and tone B, plus a flag on the last sample before
// the periodic resync. Mode 0 reads a 480-entry full-period table, mode 1
// folds a quarter table by sign and mirror, mode 2 outputs the real part of
// a rotating Q2.30 phasor scaled by 32767; phases, phasors and the sample
// counter advance on every beat in every mode. A tick beat is taken every
// clock cycle while ready is high; its result is registered in the output
// buffer. The per-beat phasor update (four 32x32 products, round and
// saturate) is combinational and closes on itself in the phasor registers.
// A two-entry output buffer takes one more tick while the output stalls;
// ready drops only while both entries are full. There is no clearing pass
// after reset. Write configuration only while no beats are in flight.
// ----------------------------------------------------------------------------
`default_nettype none
`include "dual_tone_sine_generator_assert.svh"

module dual_tone_sine_generator import dtsg_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [2:0]  cfg_index,
	input  wire logic [31:0] cfg_data,
	dtsg_in_if.sink          item,
	dtsg_out_if.source       result
);

	cfg_t      cfg;
	logic      accept;
	logic      buf_ready;
	count_t    count_q;
	count_t    count_cur;
	count_t    count_nxt;
	logic      wrap;
	tone_ctl_t ctl;
	smp_t      sample_a;
	smp_t      sample_b;
	result_t   push_data;

	dtsg_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (cfg_wr_en),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	assign item.ready = buf_ready;
	assign accept     = item.valid && buf_ready;

	assign count_cur = item.restart ? '0 : count_q;
	assign count_nxt = count_cur + 18'd1;
	assign wrap      = (count_nxt >= cfg.resync_len);

	assign ctl = '{advance: accept, restart: item.restart, resync: wrap};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= wrap ? '0 : count_nxt;
		end
	end

	dtsg_tone u_tone_a (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.mode    (cfg.mode),
		.step    (cfg.step_a),
		.rot_cos (cfg.rot_cos_a),
		.rot_sin (cfg.rot_sin_a),
		.sample  (sample_a)
	);

	dtsg_tone u_tone_b (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl),
		.mode    (cfg.mode),
		.step    (cfg.step_b),
		.rot_cos (cfg.rot_cos_b),
		.rot_sin (cfg.rot_sin_b),
		.sample  (sample_b)
	);

	assign push_data = '{sample_a: sample_a, sample_b: sample_b, wrapped: wrap};

	dtsg_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.push_data (push_data),
		.ready     (buf_ready),
		.result    (result)
	);

	`DTSG_ASSERT_NEXT(a_wrap_clears_count, clk, arst_n, accept && wrap, count_q == '0)

endmodule

`default_nettype wire

### verif/tb_dual_tone_sine_generator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_tone_sine_generator
// Self-checking bench for the dual-tone sine generator. A built-in predictor
// tracks table phases, rotating phasors and the resync counter and forms the
// expected stereo pair for every accepted tick. Directed phases cover the
// reset setup, step extremes, phasor saturation, the muted mode and a lowered
// resync length. Random phases then reprogram every register between bursts
// while both channels idle and stall at random.
// ----------------------------------------------------------------------------

module tb_dual_tone_sine_generator;
	import dtsg_pkg::*;

	localparam logic [1:0] MODE_MUTE = 2'd3;
	localparam int RANDOM_TICKS = 1850;

	typedef struct {
		logic [1:0]  mode;
		logic [7:0]  step_a;
		logic [7:0]  step_b;
		logic [31:0] cos_a;
		logic [31:0] sin_a;
		logic [31:0] cos_b;
		logic [31:0] sin_b;
		logic [17:0] resync_len;
	} tone_setup_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [2:0]  cfg_index;
	logic [31:0] cfg_data;

	dtsg_in_if  tick_ch ();
	dtsg_out_if pair_ch ();

	dual_tone_sine_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (tick_ch),
		.result    (pair_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// predictor copy of the registers
	logic [1:0]         tone_mode;
	logic [7:0]         tone_step_a, tone_step_b;
	logic signed [31:0] tone_cos_a, tone_sin_a, tone_cos_b, tone_sin_b;
	logic [17:0]        tone_len;

	// predictor copy of the generator state
	logic [8:0]         ph_a, ph_b;
	int unsigned        tick_count;
	logic signed [31:0] re_a, im_a, re_b, im_b;

	result_t pending_pairs[$];
	int      errors, ticks_sent, restarts_sent, wraps_seen, settings_used;
	bit      sender_lazy, sink_lazy;

	function automatic void resync_tones();
		ph_a = '0;
		ph_b = '0;
		tick_count = 0;
		re_a = '0;
		im_a = ONE_Q;
		re_b = '0;
		im_b = ONE_Q;
	endfunction

	function automatic smp_t full_wave(int p);
		return (p < HALF_LEN) ? WAVE_POS[p] : WAVE_NEG[p - HALF_LEN];
	endfunction

	function automatic smp_t folded_wave(int p);
		if (p < QUARTER_LEN) return WAVE_POS[p];
		if (p < HALF_LEN) return WAVE_POS[HALF_LEN - p];
		if (p < 3 * QUARTER_LEN) return -WAVE_POS[p - HALF_LEN];
		return -WAVE_POS[TABLE_LEN - p];
	endfunction

	function automatic smp_t scaled_real(logic signed [31:0] re);
		logic signed [63:0] x, y;
		x = re * SAMPLE_SCALE;
		y = (x >= 0) ? (x >>> COEF_FRAC_BITS) : -((-x) >>> COEF_FRAC_BITS);
		if (y > 32767) return 16'sh7fff;
		if (y < -32768) return 16'sh8000;
		return y[15:0];
	endfunction

	function automatic logic [8:0] step_phase(logic [8:0] p, logic [7:0] step);
		logic [9:0] n;
		n = p + step;
		if (n >= TABLE_LEN) n = n - 10'(TABLE_LEN);
		return n[8:0];
	endfunction

	function automatic logic signed [31:0] round_sat(logic signed [63:0] p1,
			logic signed [63:0] p2);
		logic signed [65:0] acc;
		acc = p1 + p2 + (66'sd1 <<< (COEF_FRAC_BITS - 1));
		acc = acc >>> COEF_FRAC_BITS;
		if (acc > 66'sd2147483647) return 32'sh7fffffff;
		if (acc < -66'sd2147483648) return 32'sh80000000;
		return acc[31:0];
	endfunction

	function automatic void spin(inout logic signed [31:0] re, inout logic signed [31:0] im,
			input logic signed [31:0] c, input logic signed [31:0] s);
		logic signed [63:0] cr, si, sr, ci;
		logic signed [31:0] nr;
		cr = c * re;
		si = s * im;
		sr = s * re;
		ci = c * im;
		nr = round_sat(cr, -si);
		im = round_sat(sr, ci);
		re = nr;
	endfunction

	function automatic result_t predict_pair(logic restart);
		result_t r;
		if (restart) resync_tones();
		case (tone_mode)
			MODE_FULL: begin
				r.sample_a = full_wave(ph_a);
				r.sample_b = full_wave(ph_b);
			end
			MODE_QUARTER: begin
				r.sample_a = folded_wave(ph_a);
				r.sample_b = folded_wave(ph_b);
			end
			MODE_PHASOR: begin
				r.sample_a = scaled_real(re_a);
				r.sample_b = scaled_real(re_b);
			end
			default: begin
				r.sample_a = '0;
				r.sample_b = '0;
			end
		endcase
		ph_a = step_phase(ph_a, tone_step_a);
		ph_b = step_phase(ph_b, tone_step_b);
		spin(re_a, im_a, tone_cos_a, tone_sin_a);
		spin(re_b, im_b, tone_cos_b, tone_sin_b);
		tick_count++;
		r.wrapped = (tick_count >= tone_len);
		if (r.wrapped) resync_tones();
		return r;
	endfunction

	function automatic tone_setup_t reset_setup();
		tone_setup_t s;
		s.mode = CFG_RESET.mode;
		s.step_a = CFG_RESET.step_a;
		s.step_b = CFG_RESET.step_b;
		s.cos_a = CFG_RESET.rot_cos_a;
		s.sin_a = CFG_RESET.rot_sin_a;
		s.cos_b = CFG_RESET.rot_cos_b;
		s.sin_b = CFG_RESET.rot_sin_b;
		s.resync_len = CFG_RESET.resync_len;
		return s;
	endfunction

	function automatic logic [31:0] rand_coef();
		if ($urandom_range(0, 2) == 0) return $urandom();
		return 32'($urandom_range(0, 32'h80000000)) - 32'h40000000;
	endfunction

	function automatic logic [7:0] rand_step();
		if ($urandom_range(0, 5) == 0) return 8'($urandom_range(0, 255));
		return 8'($urandom_range(1, 239));
	endfunction

	function automatic tone_setup_t random_setup();
		tone_setup_t s;
		int pick;
		s = reset_setup();
		pick = $urandom_range(0, 15);
		s.mode = (pick == 15) ? MODE_MUTE : 2'(pick % 3);
		s.step_a = rand_step();
		s.step_b = rand_step();
		if ($urandom_range(0, 1) == 0) begin
			// realistic small-angle rotations, direction flipped at random
			if ($urandom_range(0, 1)) s.sin_a = -CFG_RESET.rot_sin_a;
			if ($urandom_range(0, 1)) s.sin_b = -CFG_RESET.rot_sin_b;
		end else begin
			s.cos_a = rand_coef();
			s.sin_a = rand_coef();
			s.cos_b = rand_coef();
			s.sin_b = rand_coef();
		end
		case ($urandom_range(0, 9))
			0: s.resync_len = '0;
			1: s.resync_len = 18'd1;
			2: s.resync_len = 18'($urandom_range(0, 18'h3ffff));
			default: s.resync_len = 18'($urandom_range(1, 200));
		endcase
		return s;
	endfunction

	task automatic report_mismatch(input string what, input longint got, input longint want);
		errors++;
		if (errors <= 30)
			$display("MISMATCH %s: got %0d, expected %0d (tick %0d)", what, got, want,
				ticks_sent);
	endtask

	task automatic cfg_write(input cfg_reg_t idx, input logic [31:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			REG_MODE:       tone_mode = val[1:0];
			REG_STEP_A:     tone_step_a = val[7:0];
			REG_STEP_B:     tone_step_b = val[7:0];
			REG_ROT_COS_A:  tone_cos_a = val;
			REG_ROT_SIN_A:  tone_sin_a = val;
			REG_ROT_COS_B:  tone_cos_b = val;
			REG_ROT_SIN_B:  tone_sin_b = val;
			REG_RESYNC_LEN: tone_len = val[17:0];
			default: ;
		endcase
	endtask

	task automatic program_setup(input tone_setup_t s);
		cfg_write(REG_MODE, 32'(s.mode));
		cfg_write(REG_STEP_A, 32'(s.step_a));
		cfg_write(REG_STEP_B, 32'(s.step_b));
		cfg_write(REG_ROT_COS_A, s.cos_a);
		cfg_write(REG_ROT_SIN_A, s.sin_a);
		cfg_write(REG_ROT_COS_B, s.cos_b);
		cfg_write(REG_ROT_SIN_B, s.sin_b);
		cfg_write(REG_RESYNC_LEN, 32'(s.resync_len));
		cfg_wr_en <= 1'b0;
		settings_used++;
	endtask

	task automatic send_tick(input logic restart);
		int gap;
		gap = sender_lazy ? $urandom_range(0, 12) : 0;
		if (gap > 0) begin
			tick_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.restart <= restart;
		do @(posedge clk); while (tick_ch.ready !== 1'b1);
		pending_pairs.push_back(predict_pair(restart));
		ticks_sent++;
		if (restart) restarts_sent++;
	endtask

	// hold the sender until every beat is back, then let the pipe empty
	task automatic settle();
		tick_ch.valid <= 1'b0;
		while (pending_pairs.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic test_reset_defaults();
		sender_lazy = 1'b1;
		sink_lazy = 1'b1;
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
	endtask

	task automatic test_step_extremes();
		tone_setup_t s;
		s = reset_setup();
		s.mode = MODE_FULL;
		s.step_a = 8'd0;
		s.step_b = 8'd255;
		s.resync_len = 18'h3ffff;
		settle();
		program_setup(s);
		repeat (3) send_tick(1'b0);
	endtask

	task automatic test_phasor_saturation();
		tone_setup_t s;
		s = reset_setup();
		s.mode = MODE_PHASOR;
		s.cos_a = 32'h7fffffff;
		s.sin_a = 32'h80000000;
		s.cos_b = 32'hc0000000;
		s.sin_b = 32'h40000000;
		s.resync_len = 18'd3;
		settle();
		program_setup(s);
		repeat (4) send_tick(1'b0);
	endtask

	task automatic test_muted_mode();
		tone_setup_t s;
		s = reset_setup();
		s.mode = MODE_MUTE;
		s.resync_len = '0;
		settle();
		program_setup(s);
		repeat (3) send_tick(1'b0);
	endtask

	task automatic test_lowered_length();
		tone_setup_t s;
		s = reset_setup();
		s.resync_len = 18'h3ffff;
		settle();
		program_setup(s);
		repeat (5) send_tick(1'b0);
		settle();
		cfg_write(REG_RESYNC_LEN, 32'd2);
		cfg_wr_en <= 1'b0;
		repeat (2) send_tick(1'b0);
	endtask

	task automatic test_random_phases();
		int target, burst;
		bit pause_mid;
		target = ticks_sent + RANDOM_TICKS;
		while (ticks_sent < target) begin
			settle();
			program_setup(random_setup());
			sender_lazy = ($urandom_range(0, 2) != 0);
			sink_lazy = ($urandom_range(0, 2) != 0);
			burst = $urandom_range(10, 120);
			pause_mid = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < burst; i++) begin
				if (pause_mid && i == burst / 2) settle();
				send_tick($urandom_range(0, 31) == 0);
			end
		end
	endtask

	initial begin : pair_check
		result_t want;
		int stall;
		pair_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			stall = sink_lazy ? $urandom_range(0, 12) : 0;
			if (stall > 0) begin
				pair_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			pair_ch.ready <= 1'b1;
			do @(posedge clk); while (pair_ch.valid !== 1'b1);
			if (pending_pairs.size() == 0) begin
				report_mismatch("beat with nothing pending", pair_ch.sample_a, 0);
			end else begin
				want = pending_pairs.pop_front();
				if (pair_ch.sample_a !== want.sample_a)
					report_mismatch("sample_a", pair_ch.sample_a, want.sample_a);
				if (pair_ch.sample_b !== want.sample_b)
					report_mismatch("sample_b", pair_ch.sample_b, want.sample_b);
				if (pair_ch.wrapped !== want.wrapped)
					report_mismatch("wrapped", pair_ch.wrapped, want.wrapped);
				if (want.wrapped) wraps_seen++;
			end
		end
	end

	initial begin
		#3_000_000;
		$display("tb_dual_tone_sine_generator: done, errors");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		tick_ch.valid <= 1'b0;
		tick_ch.restart <= 1'b0;
		cfg_wr_en <= 1'b0;
		cfg_index <= REG_MODE;
		cfg_data <= '0;
		tone_mode = CFG_RESET.mode;
		tone_step_a = CFG_RESET.step_a;
		tone_step_b = CFG_RESET.step_b;
		tone_cos_a = CFG_RESET.rot_cos_a;
		tone_sin_a = CFG_RESET.rot_sin_a;
		tone_cos_b = CFG_RESET.rot_cos_b;
		tone_sin_b = CFG_RESET.rot_sin_b;
		tone_len = CFG_RESET.resync_len;
		resync_tones();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_defaults();
		test_step_extremes();
		test_phasor_saturation();
		test_muted_mode();
		test_lowered_length();
		test_random_phases();

		tick_ch.valid <= 1'b0;
		for (int i = 0; i < 2000 && pending_pairs.size() != 0; i++) @(posedge clk);
		repeat (8) @(posedge clk);
		if (pending_pairs.size() != 0)
			report_mismatch("pairs never delivered", 0, pending_pairs.size());

		$display("summary: %0d ticks (%0d with restart) under %0d register settings",
			ticks_sent, restarts_sent, settings_used);
		$display("summary: %0d resync wraps, all four modes, saturating coefficients",
			wraps_seen);
		if (errors == 0)
			$display("tb_dual_tone_sine_generator: done, clean");
		else
			$display("tb_dual_tone_sine_generator: done, errors");
		$finish;
	end

endmodule

### files.f
+incdir+sv
sv/dtsg_pkg.sv
sv/dtsg_in_if.sv
sv/dtsg_out_if.sv
sv/dtsg_cfg.sv
sv/dtsg_tone.sv
sv/dtsg_outbuf.sv
sv/dual_tone_sine_generator.sv
verif/tb_dual_tone_sine_generator.sv
